// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files that check themselves.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: hw/rtl/lfp_pkg.sv
// Shared types, constants and constant dividers for the lidar frame parser.
// No dependencies; the parser, queue, back end and top level import this package.
`default_nettype none
package lfp_pkg;

	localparam int FRAME_BYTES = 9;
	localparam logic [7:0] HEADER_BYTE = 8'h59;
	localparam int QUEUE_DEPTH = 4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	typedef logic [3:0] pos_t;
	localparam pos_t POS_HUNT = 4'd0;
	localparam pos_t POS_HDR2 = 4'd1;
	localparam pos_t POS_PAY0 = 4'd2;
	localparam pos_t POS_PAY3 = 4'd5;
	localparam pos_t POS_LAST = 4'(FRAME_BYTES - 1);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DISTANCE_OFFSET    = 3'd0,
		REG_VALID_MIN          = 3'd1,
		REG_VALID_MAX          = 3'd2,
		REG_STRENGTH_LEVEL_MIN = 3'd3,
		REG_NEAR_LIMIT_MM      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [9:0] distance_offset;
		logic [15:0]       valid_min;
		logic [15:0]       valid_max;
		logic [6:0]        strength_level_min;
		logic [15:0]       near_limit_mm;
	} cfg_t;

	// One completed frame handed from the parser to the back end
	typedef struct packed {
		logic        checksum_ok;
		logic [15:0] raw_distance;
		logic [15:0] strength;
		logic [15:0] near_mm;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Reciprocal multipliers, exact over the full 16-bit input range
	localparam logic [16:0] DIV10_MUL   = 17'd52429;   // shift 19
	localparam logic [16:0] DIV100_MUL  = 17'd83887;   // shift 23
	localparam logic [18:0] DIV655_MUL  = 19'd409826;  // shift 28
	localparam logic [16:0] DIV1000_MUL = 17'd67109;   // shift 26

	function automatic logic [12:0] div10(input logic [15:0] n);
		logic [32:0] p;
		p = 33'(n) * 33'(DIV10_MUL);
		return p[31:19];
	endfunction

	function automatic logic [9:0] div100(input logic [15:0] n);
		logic [32:0] p;
		p = 33'(n) * 33'(DIV100_MUL);
		return p[32:23];
	endfunction

	function automatic logic [6:0] div655(input logic [15:0] n);
		logic [34:0] p;
		p = 35'(n) * 35'(DIV655_MUL);
		return p[34:28];
	endfunction

	function automatic logic [6:0] div1000(input logic [15:0] n);
		logic [32:0] p;
		p = 33'(n) * 33'(DIV1000_MUL);
		return p[32:26];
	endfunction

	// Times 100 as shifts and adds (64 + 32 + 4)
	function automatic logic [15:0] mul100(input logic [9:0] q);
		return 16'({q, 6'b0}) + 16'({q, 5'b0}) + 16'({q, 2'b0});
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/lfp_in_if.sv
// Input channel: one received byte plus the current near sensor sample per beat.
// No dependencies.
`default_nettype none
interface lfp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rx_byte;
	logic [15:0] near_distance_mm;

	modport source (output valid, output rx_byte, output near_distance_mm, input ready);
	modport sink   (input valid, input rx_byte, input near_distance_mm, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lfp_out_if.sv
// Result channel: one beat per completed frame.
// No dependencies.
`default_nettype none
interface lfp_out_if;
	logic        valid;
	logic        ready;
	logic        checksum_ok;
	logic        source_near;
	logic [6:0]  whole_part;
	logic [6:0]  fraction_part;
	logic [15:0] held_distance_out;
	logic [6:0]  strength_level;

	modport source (output valid, output checksum_ok, output source_near,
		output whole_part, output fraction_part, output held_distance_out,
		output strength_level, input ready);
	modport sink   (input valid, input checksum_ok, input source_near,
		input whole_part, input fraction_part, input held_distance_out,
		input strength_level, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lfp_front.sv
// Byte parser: header hunt, payload capture and running sum; pushes one job per frame.
// Depends on lfp_pkg and lfp_in_if.
`default_nettype none
module lfp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	lfp_in_if.sink               in_ch,
	input  wire lfp_pkg::q_stat_t q_stat,
	output lfp_pkg::push_t       q_push
);
	import lfp_pkg::*;

	pos_t        pos_q;
	pos_t        pos_eff;
	logic [7:0]  sum_q;
	logic [31:0] pay_q;
	logic        accept;
	logic [1:0]  pay_sel;

	// Treat an out-of-range position as hunting
	assign pos_eff = (pos_q > POS_LAST) ? POS_HUNT : pos_q;
	assign pay_sel = 2'(pos_eff - POS_PAY0);

	// Stall only the closing byte while the queue is full
	assign in_ch.ready = !((pos_eff == POS_LAST) && q_stat.full);
	assign accept      = in_ch.valid && in_ch.ready;

	// Hand the finished frame to the queue
	always_comb begin
		q_push.push             = accept && (pos_eff == POS_LAST);
		q_push.job.checksum_ok  = (in_ch.rx_byte == sum_q);
		q_push.job.raw_distance = pay_q[15:0];
		q_push.job.strength     = pay_q[31:16];
		q_push.job.near_mm      = in_ch.near_distance_mm;
	end

	// Advance position and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			sum_q <= '0;
		end else if (accept) begin
			if (pos_eff == POS_HUNT) begin
				if (in_ch.rx_byte == HEADER_BYTE) begin
					sum_q <= in_ch.rx_byte;
					pos_q <= POS_HDR2;
				end else begin
					pos_q <= POS_HUNT;
				end
			end else if (pos_eff == POS_HDR2) begin
				if (in_ch.rx_byte == HEADER_BYTE) begin
					sum_q <= sum_q + in_ch.rx_byte;
					pos_q <= POS_PAY0;
				end else begin
					sum_q <= '0;
					pos_q <= POS_HUNT;
				end
			end else if (pos_eff == POS_LAST) begin
				sum_q <= '0;
				pos_q <= POS_HUNT;
			end else begin
				sum_q <= sum_q + in_ch.rx_byte;
				pos_q <= pos_eff + 4'd1;
			end
		end
	end

	// Capture distance and strength bytes; clear on second header byte
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_eff == POS_HDR2) begin
				pay_q <= '0;
			end else if (pos_eff inside {[POS_PAY0:POS_PAY3]}) begin
				pay_q[8*pay_sel +: 8] <= in_ch.rx_byte;
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/lfp_fifo.sv
// Short job queue between the parser and the back end.
// Depends on lfp_pkg. DEPTH is a power of two, at least 2.
`default_nettype none
module lfp_fifo #(
	parameter int DEPTH = lfp_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lfp_pkg::push_t   q_push,
	input  wire logic             pop,
	output lfp_pkg::job_t         head,
	output lfp_pkg::q_stat_t      q_stat
);
	import lfp_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head         = mem[rd_ptr_q];
	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (q_push.push) begin
			mem[wr_ptr_q] <= q_push.job;
		end
	end

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_push.push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (q_push.push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !q_push.push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/lfp_back.sv
// Back end: held-distance update, constant divisions, source selection, result register.
// Depends on lfp_pkg and lfp_out_if.
`default_nettype none
module lfp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lfp_pkg::cfg_t    cfg,
	input  wire lfp_pkg::job_t    job,
	input  wire lfp_pkg::q_stat_t q_stat,
	output logic                  pop,
	lfp_out_if.source             out_ch
);
	import lfp_pkg::*;

	logic        adv;
	logic [15:0] held_q;
	logic [15:0] strength_q;
	logic [15:0] held_nxt;
	logic signed [17:0] adj;
	logic        take;

	logic        vld_s1, ok_s1;
	logic [15:0] hd_s1, hs_s1, near_s1;

	logic        vld_s2, ok_s2;
	logic [15:0] hd_s2;
	logic [12:0] t_s2;
	logic [9:0]  q100_s2;
	logic [6:0]  lvl_s2, lim_s2;

	logic        vld_s3, ok_s3;
	logic [15:0] hd_s3;
	logic [12:0] t_s3;
	logic [9:0]  q100_s3, tq_s3;
	logic [15:0] hrem_s3;
	logic [6:0]  lvl_s3, lim_s3;

	logic        out_vld_q;
	logic        sel;
	logic [15:0] near_frac;

	// Whole pipeline moves when the result register is free
	assign adv = !out_vld_q || out_ch.ready;
	assign pop = adv && !q_stat.empty;

	// Adjusted distance and the held-value update rule
	always_comb begin
		adj  = $signed({2'b00, job.raw_distance}) +
			$signed({{8{cfg.distance_offset[9]}}, cfg.distance_offset});
		take = job.checksum_ok && (job.raw_distance != held_q) &&
			(adj >= $signed({2'b00, cfg.valid_min})) &&
			(adj <= $signed({2'b00, cfg.valid_max})) &&
			(adj != 18'sd65535);
		held_nxt = take ? adj[15:0] : held_q;
	end

	// Held long-range state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			strength_q <= '0;
		end else if (pop) begin
			held_q <= held_nxt;
			if (job.checksum_ok) begin
				strength_q <= job.strength;
			end
		end
	end

	// Valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= pop;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			out_vld_q <= vld_s3;
		end
	end

	// Stage 1: snapshot of the state after this frame
	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1   <= job.checksum_ok;
			hd_s1   <= held_nxt;
			hs_s1   <= job.checksum_ok ? job.strength : strength_q;
			near_s1 <= job.near_mm;
		end
	end

	// Stage 2: reciprocal multiplies
	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s2   <= ok_s1;
			hd_s2   <= hd_s1;
			t_s2    <= div10(near_s1);
			q100_s2 <= div100(hd_s1);
			lvl_s2  <= div655(hs_s1);
			lim_s2  <= div1000(cfg.near_limit_mm);
		end
	end

	// Stage 3: metres from centimetres, long-range remainder
	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s3   <= ok_s2;
			hd_s3   <= hd_s2;
			t_s3    <= t_s2;
			tq_s3   <= div100(16'(t_s2));
			q100_s3 <= q100_s2;
			hrem_s3 <= hd_s2 - mul100(q100_s2);
			lvl_s3  <= lvl_s2;
			lim_s3  <= lim_s2;
		end
	end

	// Pick the source
	always_comb begin
		near_frac = 16'(t_s3) - mul100(tq_s3);
		sel       = (lvl_s3 >= cfg.strength_level_min) && (tq_s3 < 10'(lim_s3));
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.checksum_ok       <= ok_s3;
			out_ch.source_near       <= sel;
			out_ch.held_distance_out <= hd_s3;
			out_ch.strength_level    <= lvl_s3;
			if (sel) begin
				out_ch.whole_part    <= tq_s3[6:0];
				out_ch.fraction_part <= near_frac[6:0];
			end else begin
				out_ch.whole_part    <= (q100_s3 > 10'd127) ? 7'd127 : q100_s3[6:0];
				out_ch.fraction_part <= hrem_s3[6:0];
			end
		end
	end

	assign out_ch.valid = out_vld_q;
endmodule
`default_nettype wire

// File: hw/rtl/lidar_frame_parser_range_select.sv
// Channel   Dir  Beat contents
// in_ch     in   rx_byte, near_distance_mm (one link byte each)
// out_ch    out  checksum_ok, source_near, whole_part, fraction_part,
//                held_distance_out, strength_level (one per completed frame)
// Takes one byte per cycle while in_ch.ready is high. After the closing byte, a frame
// goes through the queue read and three arithmetic stages into the result register.
// Reset clears the parser, queue, held distance and strength, and loads register
// defaults. A stalled result holds the back pipeline, then fills the job queue;
// only the closing byte of a frame waits while the queue is full.
// Top level: configuration registers and hookup of parser, job queue and back end.
// Depends on lfp_pkg, lfp_in_if, lfp_out_if, lfp_front, lfp_fifo, lfp_back.
`default_nettype none
`include "assert_macros.svh"
module lidar_frame_parser_range_select #(
	parameter int QUEUE_DEPTH = lfp_pkg::QUEUE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	lfp_in_if.sink                              in_ch,
	lfp_out_if.source                           out_ch,
	input  wire logic                           cfg_wr_en,
	input  wire logic [lfp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [lfp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lfp_pkg::*;

	cfg_t    cfg_q;
	push_t   q_push;
	q_stat_t q_stat;
	job_t    head;
	logic    q_pop;

	// Register writes; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.distance_offset    <= 10'sd0;
			cfg_q.valid_min          <= 16'd2;
			cfg_q.valid_max          <= 16'd4500;
			cfg_q.strength_level_min <= 7'd9;
			cfg_q.near_limit_mm      <= 16'd2000;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_DISTANCE_OFFSET:    cfg_q.distance_offset    <= $signed(cfg_data[9:0]);
				REG_VALID_MIN:          cfg_q.valid_min          <= cfg_data;
				REG_VALID_MAX:          cfg_q.valid_max          <= cfg_data;
				REG_STRENGTH_LEVEL_MIN: cfg_q.strength_level_min <= cfg_data[6:0];
				REG_NEAR_LIMIT_MM:      cfg_q.near_limit_mm      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_stat (q_stat),
		.q_push (q_push)
	);

	lfp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.pop    (q_pop),
		.head   (head),
		.q_stat (q_stat)
	);

	lfp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.job    (head),
		.q_stat (q_stat),
		.pop    (q_pop),
		.out_ch (out_ch)
	);

	`ASSERT_NEVER(a_push_full, clk, arst_n, q_push.push && q_stat.full, "job pushed into full queue")
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, q_pop && q_stat.empty, "job popped from empty queue")
	`ASSERT_CLK(a_push_beat, clk, arst_n, q_push.push |-> (in_ch.valid && in_ch.ready), "job without input beat")
endmodule
`default_nettype wire
